// ===== design/lrnn_pkg.sv =====
// Shared types, lookup tables and rounding helper for the liquid recurrent cell.
package lrnn_pkg;

  localparam int ACC_W = 48;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ROW   = 6'b000100,
    S_DRAIN = 6'b001000,
    S_ACT   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    PH_BIAS = 3'b001,
    PH_IN   = 3'b010,
    PH_REC  = 3'b100
  } phase_t;

  typedef enum logic [8:0] {
    A_IDLE  = 9'b000000001,
    A_Z     = 9'b000000010,
    A_TANH  = 9'b000000100,
    A_SPLUS = 9'b000001000,
    A_NORM  = 9'b000010000,
    A_RECIP = 9'b000100000,
    A_PROD  = 9'b001000000,
    A_DIV   = 9'b010000000,
    A_UPD   = 9'b100000000
  } act_state_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc;
    logic signed [15:0]      ltau;
    logic signed [15:0]      h;
  } act_req_t;

  localparam logic [11:0] TANH_TAB [17] = '{
    12'd0, 12'd1003, 12'd1893, 12'd2602, 12'd3119, 12'd3475, 12'd3707, 12'd3856,
    12'd3949, 12'd4006, 12'd4041, 12'd4062, 12'd4076, 12'd4084, 12'd4089, 12'd4091,
    12'd4093
  };

  localparam logic [15:0] SPLUS_TAB [33] = '{
    16'd1, 16'd2, 16'd4, 16'd6, 16'd10, 16'd17, 16'd28, 16'd45, 16'd74, 16'd122,
    16'd199, 16'd323, 16'd520, 16'd825, 16'd1283, 16'd1942, 16'd2839, 16'd3990,
    16'd5379, 16'd6969, 16'd8712, 16'd10563, 16'd12487, 16'd14458, 16'd16458,
    16'd18477, 16'd20508, 16'd22545, 16'd24586, 16'd26630, 16'd28676, 16'd30722,
    16'd32769
  };

  localparam logic [16:0] RECIP_TAB [17] = '{
    17'd65536, 17'd61681, 17'd58254, 17'd55188, 17'd52429, 17'd49932, 17'd47663,
    17'd45590, 17'd43691, 17'd41943, 17'd40330, 17'd38836, 17'd37449, 17'd36158,
    17'd34953, 17'd33825, 17'd32768
  };

  // Round a Q24.24 sum to Q4.12 (half up) and saturate.
  function automatic logic signed [15:0] round_q12(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] s;
    s = (a + ACC_W'(2048)) >>> 12;
    if (s > ACC_W'(32767)) return 16'sh7fff;
    else if (s < -ACC_W'(32768)) return 16'sh8000;
    else return 16'(s);
  endfunction

endpackage

// ===== design/liquid_rnn_cell_forward.sv =====
// Top level: parameter memory, hidden memory, shared MAC sequencer and output register.
// A token item is computed by one shared multiply-accumulate that reads one weight per cycle while a row streams.
// new_sequence adds a clearing pass of the hidden memory.
// After reset the same clearing pass runs; no item is accepted until it ends.
module liquid_rnn_cell_forward import lrnn_pkg::*; #(
  parameter int HIDDEN_SIZE = 32,
  parameter int VOCAB_SIZE  = 27,
  parameter int EULER_STEPS = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic [4:0]         token,
  input  logic               new_sequence,
  input  logic [11:0]        weight_addr,
  input  logic signed [15:0] weight_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         vocab_index,
  output logic signed [15:0] logit,
  output logic               last
);

  localparam int H        = HIDDEN_SIZE;
  localparam int V        = VOCAB_SIZE;
  localparam int OFF_EMB  = 0;
  localparam int OFF_WIN  = OFF_EMB + V * H;
  localparam int OFF_WHH  = OFF_WIN + H * H;
  localparam int OFF_BH   = OFF_WHH + H * H;
  localparam int OFF_LTAU = OFF_BH + H;
  localparam int OFF_WOUT = OFF_LTAU + H;
  localparam int OFF_BOUT = OFF_WOUT + V * H;
  localparam int DEPTH    = OFF_BOUT + V;
  localparam int AW       = $clog2(DEPTH);
  localparam int HIW      = $clog2(H);
  localparam int ROWS     = (H > V) ? H : V;
  localparam int RW       = $clog2(ROWS);
  localparam int SW       = $clog2(EULER_STEPS + 1);

  logic signed [15:0] wmem [DEPTH];
  logic signed [15:0] hmem [2**(HIW+1)];

  state_t      state;
  phase_t      phase, s1_ph;
  logic [RW-1:0]  row;
  logic [HIW-1:0] col, clr_idx;
  logic [SW-1:0]  stp;
  logic        mode, cur, s1_v, s2_v, boot;
  logic [4:0]  tok;

  logic signed [15:0] wa_q, wb_q, hq, opb;
  logic signed [31:0] prod;
  logic signed [ACC_W-1:0] acc;

  int          a_i, b_i;
  logic [AW-1:0]  addr_a, addr_b;
  logic [HIW:0]   haddr, hwaddr;
  logic        in_acc, wr_en, hwe, emit_go, act_start, act_done, row_last;
  logic signed [15:0] hwdata, h_new;
  act_req_t    req;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = in_acc && op && (int'(weight_addr) < DEPTH);
  assign emit_go  = (state == S_EMIT) && (!out_valid || !out_stall);
  assign act_start = (state == S_DRAIN) && !s1_v && !s2_v && !mode;
  assign row_last = mode ? (row == RW'(V - 1)) : (row == RW'(H - 1));

  always_comb begin
    a_i   = OFF_LTAU + int'(row);
    b_i   = OFF_EMB + int'(tok) * H + int'(col);
    haddr = {cur, row[HIW-1:0]};
    if (state == S_ROW) begin
      case (phase)
        PH_BIAS: a_i = (mode ? OFF_BOUT : OFF_BH) + int'(row);
        PH_IN:   a_i = OFF_WIN + int'(row) * H + int'(col);
        PH_REC: begin
          a_i   = (mode ? OFF_WOUT : OFF_WHH) + int'(row) * H + int'(col);
          haddr = {cur, col};
        end
        default: a_i = OFF_BH;
      endcase
    end
    addr_a = AW'(a_i);
    addr_b = AW'(b_i);
  end

  // Parameter memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) wmem[AW'(weight_addr)] <= weight_value;
    wa_q <= wmem[addr_a];
    wb_q <= wmem[addr_b];
  end

  // Hidden memory holds two banks; each Euler step reads one and writes the other.
  assign hwe    = (state == S_CLEAR) || act_done;
  assign hwaddr = (state == S_CLEAR) ? {cur, clr_idx} : {~cur, row[HIW-1:0]};
  assign hwdata = (state == S_CLEAR) ? 16'sd0 : h_new;

  always_ff @(posedge clk) begin
    if (hwe) hmem[hwaddr] <= hwdata;
    hq <= hmem[haddr];
  end

  // MAC pipeline: read, multiply, accumulate.
  always_comb begin
    case (s1_ph)
      PH_BIAS: opb = 16'sd4096;
      PH_IN:   opb = wb_q;
      PH_REC:  opb = hq;
      default: opb = 16'sd0;
    endcase
  end

  // The sum is cleared while a row fills the pipeline and held until the next row.
  always_ff @(posedge clk) begin
    s1_ph <= phase;
    prod  <= wa_q * opb;
    if (s2_v) acc <= acc + ACC_W'(prod);
    else if (state == S_ROW) acc <= '0;
  end

  assign req.acc  = acc;
  assign req.ltau = wa_q;
  assign req.h    = hq;

  lrnn_act #(.EULER_STEPS(EULER_STEPS)) u_act (
    .clk   (clk),
    .rst   (rst),
    .start (act_start),
    .req   (req),
    .done  (act_done),
    .h_new (h_new)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      phase     <= PH_BIAS;
      row       <= '0;
      col       <= '0;
      clr_idx   <= '0;
      stp       <= '0;
      mode      <= 1'b0;
      cur       <= 1'b0;
      boot      <= 1'b1;
      tok       <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_v <= (state == S_ROW);
      s2_v <= s1_v;
      if (emit_go) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == HIW'(H - 1)) begin
            boot  <= 1'b0;
            state <= boot ? S_IDLE : S_ROW;
          end
        end
        S_IDLE: begin
          if (in_acc && !op) begin
            tok     <= (int'(token) < V) ? token : 5'd0;
            row     <= '0;
            col     <= '0;
            stp     <= '0;
            mode    <= 1'b0;
            phase   <= PH_BIAS;
            clr_idx <= '0;
            state   <= new_sequence ? S_CLEAR : S_ROW;
          end
        end
        S_ROW: begin
          case (phase)
            PH_BIAS: begin
              phase <= mode ? PH_REC : PH_IN;
              col   <= '0;
            end
            PH_IN: begin
              if (col == HIW'(H - 1)) begin
                phase <= PH_REC;
                col   <= '0;
              end else begin
                col <= col + 1'b1;
              end
            end
            PH_REC: begin
              if (col == HIW'(H - 1)) begin
                col   <= '0;
                state <= S_DRAIN;
              end else begin
                col <= col + 1'b1;
              end
            end
            default: phase <= PH_BIAS;
          endcase
        end
        S_DRAIN: begin
          if (!s1_v && !s2_v) state <= mode ? S_EMIT : S_ACT;
        end
        S_ACT: begin
          if (act_done) begin
            phase <= PH_BIAS;
            state <= S_ROW;
            if (row_last) begin
              row <= '0;
              cur <= ~cur;
              if (stp == SW'(EULER_STEPS - 1)) mode <= 1'b1;
              else stp <= stp + 1'b1;
            end else begin
              row <= row + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            phase <= PH_BIAS;
            if (row_last) begin
              state <= S_IDLE;
            end else begin
              row   <= row + 1'b1;
              state <= S_ROW;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      vocab_index <= 5'(row);
      logit       <= round_q12(acc);
      last        <= row_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> state == S_IDLE) else $error("weight write outside idle");
  a_act_after_drain: assert property (@(posedge clk) disable iff (rst)
    act_done |-> state == S_ACT) else $error("activation result with no waiting row");
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (emit_go && row_last) |=> state == S_IDLE && out_valid && last)
    else $error("final logit did not end the transaction");
  a_pipe_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_ACT || state == S_EMIT) |-> !s1_v && !s2_v)
    else $error("MAC pipeline busy after drain");
`endif

endmodule

// ===== design/lrnn_act.sv =====
// Multicycle activation and Euler update unit for one hidden neuron.
module lrnn_act import lrnn_pkg::*; #(
  parameter int EULER_STEPS = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  act_req_t           req,
  output logic               done,
  output logic signed [15:0] h_new
);

  localparam logic [63:0] DIV_M64 = ((64'd1 << 32) + 64'(EULER_STEPS) - 64'd1) / 64'(EULER_STEPS);
  localparam logic [32:0] DIV_M = DIV_M64[32:0];

  act_state_t state;
  act_req_t   r;
  logic signed [15:0] z, f;
  logic [15:0] tau, m;
  logic [3:0]  k;
  logic [24:0] inv;
  logic signed [29:0] d;
  logic        dneg;
  logic [28:0] q;

  logic [16:0] mag;
  logic [11:0] t_c;
  logic [15:0] u, tau_c, m_c;
  logic [3:0]  k_c;
  logic [16:0] r_c;
  logic [24:0] inv_c;
  logic signed [16:0] dif;
  logic signed [42:0] p;
  logic signed [29:0] d_c;
  logic [28:0] dmag;
  logic [61:0] qp;
  logic signed [30:0] hsum;
  logic signed [15:0] hn_c;

  always_comb begin
    // tanh by interpolation on |z|.
    mag = z[15] ? 17'(-17'(z)) : 17'(z);
    if (mag >= 17'd16384) begin
      t_c = TANH_TAB[16];
    end else begin
      t_c = TANH_TAB[mag[13:10]] + 12'((21'(TANH_TAB[5'(mag[13:10]) + 5'd1]
            - TANH_TAB[mag[13:10]]) * 21'(mag[9:0])) >> 10);
    end
    // softplus of the log time constant.
    u = r.ltau ^ 16'h8000;
    tau_c = SPLUS_TAB[u[15:11]] + 16'((23'(SPLUS_TAB[6'(u[15:11]) + 6'd1]
            - SPLUS_TAB[u[15:11]]) * 23'(u[10:0])) >> 11);
    // Normalize tau so the mantissa has its top bit set.
    k_c = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (tau[i]) k_c = 4'(i);
    end
    m_c = tau << (4'd15 - k_c);
    r_c = RECIP_TAB[m[14:11]] - 17'((25'(RECIP_TAB[m[14:11]]
          - RECIP_TAB[5'(m[14:11]) + 5'd1]) * 25'(m[10:3])) >> 8);
    inv_c = (k <= 4'd8) ? (25'(r_c) << (4'd8 - k)) : (25'(r_c) >> (k - 4'd8));
    dif = 17'(f) - 17'(r.h);
    p = dif * $signed({1'b0, inv});
    d_c = 30'((p + 43'sd2048) >>> 12);
    dmag = d[29] ? 29'(-d) : 29'(d);
    qp = 62'(dmag) * 62'(DIV_M);
    hsum = 31'(r.h) + (dneg ? -31'($signed({1'b0, q})) : 31'($signed({1'b0, q})));
    if (hsum > 31'sd32767) hn_c = 16'sh7fff;
    else if (hsum < -31'sd32768) hn_c = 16'sh8000;
    else hn_c = 16'(hsum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == A_UPD);
      case (state)
        A_IDLE:  if (start) state <= A_Z;
        A_Z:     state <= A_TANH;
        A_TANH:  state <= A_SPLUS;
        A_SPLUS: state <= A_NORM;
        A_NORM:  state <= A_RECIP;
        A_RECIP: state <= A_PROD;
        A_PROD:  state <= A_DIV;
        A_DIV:   state <= A_UPD;
        A_UPD:   state <= A_IDLE;
        default: state <= A_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      A_IDLE:  if (start) r <= req;
      A_Z:     z <= round_q12(r.acc);
      A_TANH:  f <= z[15] ? -16'($signed({4'b0, t_c})) : 16'($signed({4'b0, t_c}));
      A_SPLUS: tau <= tau_c;
      A_NORM: begin
        k <= k_c;
        m <= m_c;
      end
      A_RECIP: inv <= inv_c;
      A_PROD:  d <= d_c;
      A_DIV: begin
        dneg <= d[29];
        q    <= 29'(qp >> 32);
      end
      A_UPD:   h_new <= hn_c;
      default: ;
    endcase
  end

endmodule

// ===== bench/liquid_rnn_cell_forward_checker.sv =====
// Checker for the liquid recurrent cell: predicts logits per token and compares them.
module liquid_rnn_cell_forward_checker import lrnn_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic               op,
  input  logic [4:0]         token,
  input  logic               new_sequence,
  input  logic [11:0]        weight_addr,
  input  logic signed [15:0] weight_value,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [4:0]         vocab_index,
  input  logic signed [15:0] logit,
  input  logic               last,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HID = 32;
  localparam int VOC = 27;
  localparam int STEPS = 2;
  localparam int OFS_EMB = 0;
  localparam int OFS_WIN = OFS_EMB + VOC * HID;
  localparam int OFS_WHH = OFS_WIN + HID * HID;
  localparam int OFS_BH = OFS_WHH + HID * HID;
  localparam int OFS_LTAU = OFS_BH + HID;
  localparam int OFS_WOUT = OFS_LTAU + HID;
  localparam int OFS_BOUT = OFS_WOUT + VOC * HID;
  localparam int DEPTH = OFS_BOUT + VOC;
  localparam logic OP_TOKEN = 1'b0;

  typedef struct packed {
    logic [4:0]         idx;
    logic signed [15:0] score;
    logic               fin;
  } logit_t;

  logic signed [15:0] params [DEPTH];
  logic signed [15:0] hidden [HID];
  logit_t expected_logits [$];

  assign pending = expected_logits.size();

  function automatic logic signed [15:0] clip16(longint a);
    if (a > 32767) return 16'sh7fff;
    if (a < -32768) return 16'sh8000;
    return 16'(a);
  endfunction

  function automatic logic signed [15:0] to_q12(longint a);
    return clip16((a + 2048) >>> 12);
  endfunction

  function automatic int squash(logic signed [15:0] z);
    int mag, ix, fr, res;
    mag = (z < 0) ? -int'(z) : int'(z);
    if (mag >= 16384) res = int'(TANH_TAB[16]);
    else begin
      ix = mag >> 10;
      fr = mag & 1023;
      res = int'(TANH_TAB[ix]) + (((int'(TANH_TAB[ix+1]) - int'(TANH_TAB[ix])) * fr) >> 10);
    end
    return (z < 0) ? -res : res;
  endfunction

  // Time constant from its log, then its reciprocal in unsigned Q.12.
  function automatic int unsigned inv_tau(logic signed [15:0] lt);
    int unsigned u, ix, fr, t, k, m, off, r;
    u = (int'(lt) + 32768) & 32'hffff;
    ix = u >> 11;
    fr = u & 2047;
    t = SPLUS_TAB[ix] + (((SPLUS_TAB[ix+1] - SPLUS_TAB[ix]) * fr) >> 11);
    if (t == 0) t = 1;
    if (t > 65535) t = 65535;
    k = 0;
    while (k < 15 && (t >> (k + 1)) != 0) k++;
    m = t << (15 - k);
    off = m - 32768;
    ix = off >> 11;
    fr = (off >> 3) & 255;
    r = RECIP_TAB[ix] - (((RECIP_TAB[ix] - RECIP_TAB[ix+1]) * fr) >> 8);
    return (k <= 8) ? (r << (8 - k)) : (r >> (k - 8));
  endfunction

  task automatic predict_token(logic [4:0] tok, logic clear);
    longint drive [HID];
    logic signed [15:0] nxt [HID];
    longint acc, delta;
    int row, f;
    logit_t item;
    row = (tok >= VOC) ? 0 : int'(tok);
    if (clear) foreach (hidden[i]) hidden[i] = '0;
    for (int n = 0; n < HID; n++) begin
      acc = longint'(params[OFS_BH + n]) * 4096;
      for (int c = 0; c < HID; c++)
        acc += longint'(params[OFS_WIN + n*HID + c]) * longint'(params[OFS_EMB + row*HID + c]);
      drive[n] = acc;
    end
    for (int s = 0; s < STEPS; s++) begin
      for (int n = 0; n < HID; n++) begin
        acc = drive[n];
        for (int c = 0; c < HID; c++)
          acc += longint'(params[OFS_WHH + n*HID + c]) * longint'(hidden[c]);
        f = squash(to_q12(acc));
        delta = ((longint'(f - int'(hidden[n])) * longint'(inv_tau(params[OFS_LTAU + n]))
                 + 2048) >>> 12) / STEPS;
        nxt[n] = clip16(longint'(hidden[n]) + delta);
      end
      hidden = nxt;
    end
    for (int v = 0; v < VOC; v++) begin
      acc = longint'(params[OFS_BOUT + v]) * 4096;
      for (int c = 0; c < HID; c++)
        acc += longint'(params[OFS_WOUT + v*HID + c]) * longint'(hidden[c]);
      item.idx = 5'(v);
      item.score = to_q12(acc);
      item.fin = (v == VOC - 1);
      expected_logits.push_back(item);
    end
  endtask

  initial begin
    errors = 0;
    foreach (params[i]) params[i] = '0;
    foreach (hidden[i]) hidden[i] = '0;
  end

  always @(posedge clk) begin
    logit_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        if (op == OP_TOKEN) predict_token(token, new_sequence);
        else if (weight_addr < DEPTH) params[weight_addr] = weight_value;
      end
      if (out_valid && !out_stall) begin
        if (expected_logits.size() == 0) begin
          errors++;
          $display("%0t: unexpected logit transaction: index %0d logit %0d last %0b",
                   $time, vocab_index, logit, last);
        end else begin
          want = expected_logits.pop_front();
          if (vocab_index !== want.idx) begin
            errors++;
            $display("%0t: vocab_index expected %0d actual %0d", $time, want.idx, vocab_index);
          end
          if (logit !== want.score) begin
            errors++;
            $display("%0t: logit[%0d] expected %0d actual %0d", $time, want.idx,
                     want.score, logit);
          end
          if (last !== want.fin) begin
            errors++;
            $display("%0t: last[%0d] expected %0b actual %0b", $time, want.idx,
                     want.fin, last);
          end
        end
      end
    end
  end

endmodule

// ===== bench/liquid_rnn_cell_forward_tb.sv =====
// Top of the liquid recurrent cell testbench: stimulus, receiver stalls and verdict.
module liquid_rnn_cell_forward_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic OP_TOKEN = 1'b0;
  localparam logic OP_WRITE = 1'b1;
  localparam int DEPTH = 3867;
  localparam int OFS_LTAU = 3867 - 27 - 27*32 - 32;
  localparam int IDLE_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = OP_WRITE;
  logic [4:0] token = '0;
  logic new_sequence = 1'b0;
  logic [11:0] weight_addr = '0;
  logic signed [15:0] weight_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [4:0] vocab_index;
  logic signed [15:0] logit;
  logic last;
  int errors, pending;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  liquid_rnn_cell_forward uut (.*);

  liquid_rnn_cell_forward_checker checker_i (.*);

  // Receiver stalls: the mode changes now and then, and mode zero never stalls.
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    out_stall <= (stall_mode == 0) ? 1'b0 : ($urandom_range(0, 3) < stall_mode);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("liquid_rnn_cell_forward regression: fail");
      $finish;
    end
  end

  task automatic send(logic kind, logic [4:0] tok, logic clear, logic [11:0] addr,
                      logic signed [15:0] value);
    in_valid <= 1'b1;
    op <= kind;
    token <= tok;
    new_sequence <= clear;
    weight_addr <= addr;
    weight_value <= value;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  function automatic logic signed [15:0] rand_weight(int span);
    return 16'($signed($urandom_range(0, 2*span)) - span);
  endfunction

  task automatic write_weight(int addr, logic signed [15:0] value);
    send(OP_WRITE, 5'($urandom), 1'($urandom), 12'(addr), value);
  endtask

  task automatic run_token(logic [4:0] tok, logic clear);
    send(OP_TOKEN, tok, clear, 12'($urandom), 16'($urandom));
  endtask

  initial begin
    logic signed [15:0] w;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    // Load every weight; most are small so the cell stays out of saturation.
    for (int a = 0; a < DEPTH; a++) begin
      if (a >= OFS_LTAU && a < OFS_LTAU + 32) w = 16'($urandom);
      else if ($urandom_range(0, 99) == 0) w = 16'($urandom);
      else w = rand_weight(1500);
      write_weight(a, w);
    end
    // Extreme time constants and weight values, and writes past the end of the parameter memory.
    write_weight(OFS_LTAU, 16'sh8000);
    write_weight(OFS_LTAU + 1, 16'sh7fff);
    write_weight(5, 16'sh7fff);
    write_weight(6, 16'sh8000);
    write_weight(DEPTH, 16'sh1234);
    write_weight(4095, 16'sh7fff);
    run_token(5'd0, 1'b1);
    run_token(5'd26, 1'b0);
    run_token(5'd1, 1'b0);
    run_token(5'd31, 1'b0);
    run_token(5'd27, 1'b1);
    run_token(5'd13, 1'b1);
    run_token(5'd26, 1'b0);
    for (int i = 0; i < 120; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        run_token(($urandom_range(0, 9) == 0) ? 5'($urandom_range(27, 31))
                                             : 5'($urandom_range(0, 26)),
                  ($urandom_range(0, 3) == 0));
      end else begin
        w = ($urandom_range(0, 3) == 0) ? 16'($urandom) : rand_weight(1500);
        write_weight(($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH, 4095)
                                                 : $urandom_range(0, DEPTH - 1), w);
      end
    end
    in_valid <= 1'b0;
    // One more edge so the checker has seen the final transaction.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("liquid_rnn_cell_forward regression: pass");
    else $display("liquid_rnn_cell_forward regression: fail");
    $finish;
  end

endmodule
